>>> hw/rtl/csh_pkg.sv
// shared constants, codes and controller/datapath interface types
// for the contrast stretch histogram block; no dependencies
package csh_pkg;

  // sizes
  localparam int unsigned LEVELS       = 256;
  localparam int unsigned COUNT_BITS   = 20;
  localparam int unsigned ADDR_BITS    = $clog2(LEVELS);
  localparam int unsigned PIX_BITS     = 8;
  localparam int unsigned SPAN_BITS    = 9;
  localparam int unsigned PROD_BITS    = PIX_BITS + SPAN_BITS;
  localparam int unsigned OUT_CNT_BITS = 20;
  localparam int unsigned DIV_STEPS    = PIX_BITS;
  localparam int unsigned DIV_CNT_BITS = $clog2(DIV_STEPS);

  // fixed values
  localparam logic [SPAN_BITS-1:0] SPAN_RESET = 9'd256;
  localparam logic [PIX_BITS-1:0]  TOP_LEVEL  = 8'd255;

  // request codes
  typedef enum logic [1:0] {
    FUNC_STAT = 2'd0,
    FUNC_MAP  = 2'd1,
    FUNC_READ = 2'd2,
    FUNC_NONE = 2'd3
  } func_e;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STAT,
    ST_MUL,
    ST_CHK,
    ST_DIV,
    ST_HRD,
    ST_HWR,
    ST_RRD,
    ST_ACC,
    ST_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic stat;
    logic mul;
    logic chk;
    logic div_step;
    logic h_read;
    logic h_write;
    logic r_read;
    logic r_acc;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic skip_div;
    logic div_done;
  } sts_t;

endpackage

>>> hw/rtl/csh_ctrl.sv
// controller state machine and output word handshake
// depends on csh_pkg
module csh_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [1:0]    func_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  csh_pkg::sts_t sts_i,
  output csh_pkg::cmd_t cmd_o
);

  csh_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;

  // state and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= csh_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      csh_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          unique case (csh_pkg::func_e'(func_i))
            csh_pkg::FUNC_STAT: state_d = csh_pkg::ST_STAT;
            csh_pkg::FUNC_MAP:  state_d = csh_pkg::ST_MUL;
            csh_pkg::FUNC_READ: state_d = csh_pkg::ST_RRD;
            csh_pkg::FUNC_NONE: state_d = csh_pkg::ST_DONE;
            default:            state_d = csh_pkg::ST_DONE;
          endcase
        end
      end
      csh_pkg::ST_STAT: begin
        cmd_o.stat = 1'b1;
        state_d    = csh_pkg::ST_DONE;
      end
      csh_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = csh_pkg::ST_CHK;
      end
      csh_pkg::ST_CHK: begin
        cmd_o.chk = 1'b1;
        state_d   = sts_i.skip_div ? csh_pkg::ST_HRD : csh_pkg::ST_DIV;
      end
      csh_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = csh_pkg::ST_HRD;
        end
      end
      csh_pkg::ST_HRD: begin
        cmd_o.h_read = 1'b1;
        state_d      = csh_pkg::ST_HWR;
      end
      csh_pkg::ST_HWR: begin
        cmd_o.h_write = 1'b1;
        state_d       = csh_pkg::ST_DONE;
      end
      csh_pkg::ST_RRD: begin
        cmd_o.r_read = 1'b1;
        state_d      = csh_pkg::ST_ACC;
      end
      csh_pkg::ST_ACC: begin
        cmd_o.r_acc = 1'b1;
        state_d     = csh_pkg::ST_DONE;
      end
      csh_pkg::ST_DONE: begin
        // hand the word over once the output register is free
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = csh_pkg::ST_IDLE;
        end
      end
      default: state_d = csh_pkg::ST_IDLE;
    endcase
  end

  // output register occupancy
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign in_stall_o  = (state_q != csh_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> hw/rtl/csh_dpath.sv
// datapath: min/max tracking, multiplier, radix-2 divider,
// histogram memory with valid bits, readout accumulator; depends on csh_pkg
module csh_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  csh_pkg::cmd_t                       cmd_i,
  output csh_pkg::sts_t                       sts_o,
  input  logic [1:0]                          func_i,
  input  logic [csh_pkg::PIX_BITS-1:0]        pixel_i,
  input  logic                                frame_start_i,
  input  logic [csh_pkg::PIX_BITS-1:0]        bin_i,
  input  logic                                cfg_we_i,
  input  logic [csh_pkg::SPAN_BITS-1:0]       cfg_data_i,
  output logic [csh_pkg::PIX_BITS-1:0]        stretched_o,
  output logic                                range_zero_o,
  output logic [csh_pkg::OUT_CNT_BITS-1:0]    bin_count_o,
  output logic [csh_pkg::OUT_CNT_BITS-1:0]    cumulative_count_o
);

  localparam int unsigned PB = csh_pkg::PIX_BITS;
  localparam int unsigned CB = csh_pkg::COUNT_BITS;
  localparam int unsigned AB = csh_pkg::ADDR_BITS;
  localparam logic [CB-1:0] COUNT_MAX = '1;

  // captured request
  csh_pkg::func_e func_q;
  logic [PB-1:0]  pixel_q;
  logic           fs_q;
  logic [PB-1:0]  bin_q;

  // state with reset values
  logic [csh_pkg::SPAN_BITS-1:0] span_q;
  logic [PB-1:0]                 min_q, min_d;
  logic [PB-1:0]                 max_q, max_d;
  logic [CB-1:0]                 total_q, total_d;
  logic [csh_pkg::LEVELS-1:0]    vld_q;

  // map pass
  logic [csh_pkg::PROD_BITS-1:0] prod_q;
  logic [PB-1:0]                 dvs_q;
  logic                          flat_q, below_q, zero_q;
  logic                          over;
  logic [PB-1:0]                 rem_q, shf_q, quo_q, level_q;
  logic [PB:0]                   trial;
  logic                          ge;
  logic [PB-1:0]                 rem_nx, quo_nx;
  logic [csh_pkg::DIV_CNT_BITS-1:0] cnt_div_q;

  // histogram
  logic [CB-1:0] mem [csh_pkg::LEVELS];
  logic [CB-1:0] rd_data_q;
  logic          rd_vld_q, hit_q;
  logic [31:0]   lvl_w, bin_w, sel_w;
  logic [AB-1:0] lvl_addr, sel_addr;
  logic          sel_hit;
  logic [CB-1:0] cur, inc, cnt_q;
  logic [CB:0]   sum;
  logic [CB-1:0] base;
  logic [31:0]   cnt_w, total_w;

  // input capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q  <= csh_pkg::func_e'(func_i);
      pixel_q <= pixel_i;
      fs_q    <= frame_start_i;
      bin_q   <= bin_i;
    end
  end

  // min/max update, frame start restarts from the reset levels
  always_comb begin
    logic [PB-1:0] min_b, max_b;
    min_b = fs_q ? csh_pkg::TOP_LEVEL : min_q;
    max_b = fs_q ? '0 : max_q;
    min_d = (pixel_q < min_b) ? pixel_q : min_b;
    max_d = (pixel_q > max_b) ? pixel_q : max_b;
  end

  // readout accumulation, restarts at bin zero
  assign base    = (bin_q == '0) ? '0 : total_q;
  assign sum     = {1'b0, base} + {1'b0, cur};
  assign total_d = sum[CB] ? COUNT_MAX : sum[CB-1:0];

  // registers with reset values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_q  <= csh_pkg::SPAN_RESET;
      min_q   <= csh_pkg::TOP_LEVEL;
      max_q   <= '0;
      total_q <= '0;
      vld_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        span_q <= cfg_data_i;
      end
      if (cmd_i.stat) begin
        min_q <= min_d;
        max_q <= max_d;
        if (fs_q) begin
          total_q <= '0;
          vld_q   <= '0;
        end
      end
      if (cmd_i.r_acc) begin
        total_q <= total_d;
      end
      if (cmd_i.h_write && hit_q) begin
        vld_q[lvl_addr] <= 1'b1;
      end
    end
  end

  // divider step and overflow check
  assign over   = prod_q >= csh_pkg::PROD_BITS'({dvs_q, {PB{1'b0}}});
  assign trial  = {rem_q, shf_q[PB-1]};
  assign ge     = trial >= {1'b0, dvs_q};
  assign rem_nx = ge ? PB'(trial - {1'b0, dvs_q}) : trial[PB-1:0];
  assign quo_nx = {quo_q[PB-2:0], ge};

  assign sts_o.skip_div = flat_q | below_q | over;
  assign sts_o.div_done = (cnt_div_q == csh_pkg::DIV_CNT_BITS'(csh_pkg::DIV_STEPS - 1));

  // multiply, check and iterate
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q  <= csh_pkg::PROD_BITS'(pixel_q - min_q) * csh_pkg::PROD_BITS'(span_q);
      dvs_q   <= max_q - min_q;
      flat_q  <= (max_q <= min_q);
      below_q <= (pixel_q <= min_q);
    end
    if (cmd_i.chk) begin
      zero_q    <= flat_q;
      level_q   <= (flat_q || below_q) ? '0 : csh_pkg::TOP_LEVEL;
      rem_q     <= prod_q[2*PB-1:PB];
      shf_q     <= prod_q[PB-1:0];
      quo_q     <= '0;
      cnt_div_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q     <= rem_nx;
      shf_q     <= {shf_q[PB-2:0], 1'b0};
      quo_q     <= quo_nx;
      cnt_div_q <= cnt_div_q + 1'b1;
      if (sts_o.div_done) begin
        level_q <= quo_nx;
      end
    end
  end

  // histogram addressing, out-of-store levels are neither counted nor read
  assign lvl_w    = 32'(level_q);
  assign bin_w    = 32'(bin_q);
  assign lvl_addr = lvl_w[AB-1:0];
  assign sel_w    = cmd_i.h_read ? lvl_w : bin_w;
  assign sel_addr = sel_w[AB-1:0];
  assign sel_hit  = sel_w < 32'(csh_pkg::LEVELS);

  assign cur = (rd_vld_q && hit_q) ? rd_data_q : '0;
  assign inc = (cur == COUNT_MAX) ? cur : cur + 1'b1;

  // histogram memory, registered read then write back
  always_ff @(posedge clk_i) begin
    if (cmd_i.h_read || cmd_i.r_read) begin
      rd_data_q <= mem[sel_addr];
      rd_vld_q  <= vld_q[sel_addr];
      hit_q     <= sel_hit;
    end
    if (cmd_i.h_write && hit_q) begin
      mem[lvl_addr] <= inc;
    end
    if (cmd_i.r_read) begin
      cnt_q <= '0;
    end
    if (cmd_i.r_acc) begin
      cnt_q <= cur;
    end
  end

  // output word register
  assign cnt_w   = 32'(cnt_q);
  assign total_w = 32'(total_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      stretched_o        <= (func_q == csh_pkg::FUNC_MAP) ? level_q : '0;
      range_zero_o       <= (func_q == csh_pkg::FUNC_MAP) && zero_q;
      bin_count_o        <= (func_q == csh_pkg::FUNC_READ) ?
                            cnt_w[csh_pkg::OUT_CNT_BITS-1:0] : '0;
      cumulative_count_o <= (func_q == csh_pkg::FUNC_READ) ?
                            total_w[csh_pkg::OUT_CNT_BITS-1:0] : '0;
    end
  end

endmodule

>>> hw/rtl/contrast_stretch_histogram.sv
// top level of the contrast stretch histogram block
// depends on csh_pkg, csh_ctrl and csh_dpath
//
//   port group     direction  handshake              payload
//   in             to block   in_valid_i/in_stall_o  func_i pixel_i frame_start_i bin_i
//   out            from block out_valid_o/out_stall_i stretched_o range_zero_o
//                                                     bin_count_o cumulative_count_o
//   cfg            to block   cfg_we_i               cfg_data_i (output span)
//
// one word at a time; a map word runs multiply, clamp check, 8 steps of the radix-2
// divider, histogram read and write back, but skips the divider when flat, below
// minimum or clamped; a gather word updates min/max, a readout word reads one bin
// and adds it to the running total, and the unused code only returns a word.
// reset clears min/max, the running total and all histogram valid bits at once.
// the output register lets the result wait under out_stall_i; the next word
// is taken while it waits, and only a second finished result holds the block.
module contrast_stretch_histogram (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          func_i,
  input  logic [csh_pkg::PIX_BITS-1:0]        pixel_i,
  input  logic                                frame_start_i,
  input  logic [csh_pkg::PIX_BITS-1:0]        bin_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [csh_pkg::PIX_BITS-1:0]        stretched_o,
  output logic                                range_zero_o,
  output logic [csh_pkg::OUT_CNT_BITS-1:0]    bin_count_o,
  output logic [csh_pkg::OUT_CNT_BITS-1:0]    cumulative_count_o,
  input  logic                                cfg_we_i,
  input  logic [csh_pkg::SPAN_BITS-1:0]       cfg_data_i
);

  csh_pkg::cmd_t cmd;
  csh_pkg::sts_t sts;

  // controller
  csh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath
  csh_dpath u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .func_i             (func_i),
    .pixel_i            (pixel_i),
    .frame_start_i      (frame_start_i),
    .bin_i              (bin_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_data_i         (cfg_data_i),
    .stretched_o        (stretched_o),
    .range_zero_o       (range_zero_o),
    .bin_count_o        (bin_count_o),
    .cumulative_count_o (cumulative_count_o)
  );

endmodule

>>> tb/testbench.sv
// self-checking bench for contrast_stretch_histogram: random and directed words
// checked against an in-bench predictor of min/max stretching and the histogram
// depends on csh_pkg and the contrast_stretch_histogram rtl
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // one request word and one result word
  typedef struct packed {
    csh_pkg::func_e func;
    logic [7:0]    pixel;
    logic          frame_start;
    logic [7:0]    bin;
  } pixel_word_t;

  typedef struct packed {
    logic [7:0]    stretched;
    logic          range_zero;
    logic [19:0]   bin_count;
    logic [19:0]   cumulative;
  } stretch_result_t;

  // clock, reset and dut ports
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall_o;
  logic [1:0]  in_func = 2'd0;
  logic [7:0]  in_pixel = 8'd0;
  logic        in_frame_start = 1'b0;
  logic [7:0]  in_bin = 8'd0;
  logic        out_valid_o;
  logic        out_stall = 1'b0;
  logic [7:0]  stretched_o;
  logic        range_zero_o;
  logic [19:0] bin_count_o;
  logic [19:0] cumulative_count_o;
  logic        cfg_we = 1'b0;
  logic [8:0]  cfg_data = 9'd0;

  // predictor state
  logic [8:0]  span_now;
  logic [7:0]  lo_seen;
  logic [7:0]  hi_seen;
  logic [19:0] bin_tally [csh_pkg::LEVELS];
  logic [19:0] running_sum;

  // bench bookkeeping
  pixel_word_t     words_to_send [$];
  stretch_result_t results_due [$];
  pixel_word_t     next_word;
  stretch_result_t got_result;
  stretch_result_t want_result;
  int unsigned     error_count = 0;
  bit              steady = 1'b0;

  contrast_stretch_histogram uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall_o),
    .func_i             (in_func),
    .pixel_i            (in_pixel),
    .frame_start_i      (in_frame_start),
    .bin_i              (in_bin),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall),
    .stretched_o        (stretched_o),
    .range_zero_o       (range_zero_o),
    .bin_count_o        (bin_count_o),
    .cumulative_count_o (cumulative_count_o),
    .cfg_we_i           (cfg_we),
    .cfg_data_i         (cfg_data)
  );

  // clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // saturating add at the count width
  function automatic logic [19:0] sat_add(input logic [19:0] a, input logic [19:0] b);
    logic [20:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[20] ? 20'hFFFFF : s[19:0];
  endfunction

  // clear statistics and histogram, as reset and frame start do
  task automatic clear_stats();
    lo_seen = 8'd255;
    hi_seen = 8'd0;
    running_sum = '0;
    foreach (bin_tally[i]) bin_tally[i] = '0;
  endtask

  // expected result of one accepted word; updates the predictor state
  function automatic stretch_result_t stretch_predict(input pixel_word_t w);
    stretch_result_t r;
    logic [7:0]  diff;
    logic [7:0]  spread;
    logic [16:0] num;
    logic [16:0] quo;
    logic [7:0]  lvl;
    logic [19:0] c;
    r = '0;
    case (w.func)
      csh_pkg::FUNC_STAT: begin
        if (w.frame_start) begin
          lo_seen = 8'd255;
          hi_seen = 8'd0;
          running_sum = '0;
          foreach (bin_tally[i]) bin_tally[i] = '0;
        end
        if (w.pixel < lo_seen) lo_seen = w.pixel;
        if (w.pixel > hi_seen) hi_seen = w.pixel;
      end
      csh_pkg::FUNC_MAP: begin
        lvl = '0;
        if (hi_seen <= lo_seen) begin
          r.range_zero = 1'b1;
        end else if (w.pixel > lo_seen) begin
          diff = w.pixel - lo_seen;
          spread = hi_seen - lo_seen;
          num = {9'd0, diff} * {8'd0, span_now};
          quo = num / {9'd0, spread};
          lvl = (quo > 17'd255) ? csh_pkg::TOP_LEVEL : quo[7:0];
        end
        r.stretched = lvl;
        bin_tally[lvl] = sat_add(bin_tally[lvl], 20'd1);
      end
      csh_pkg::FUNC_READ: begin
        c = bin_tally[w.bin];
        if (w.bin == 8'd0) running_sum = '0;
        running_sum = sat_add(running_sum, c);
        r.bin_count = c;
        r.cumulative = running_sum;
      end
      default: ;
    endcase
    return r;
  endfunction

  // driver: take the next word once the current one is accepted
  always @(posedge clk_i) begin
    if (in_valid && !in_stall_o) begin
      results_due.push_back(stretch_predict({csh_pkg::func_e'(in_func), in_pixel,
                                             in_frame_start, in_bin}));
    end
    if (!in_valid || !in_stall_o) begin
      if (rst_ni && words_to_send.size() != 0 && (steady || $urandom_range(0, 99) >= 15)) begin
        next_word = words_to_send.pop_front();
        in_valid <= 1'b1;
        in_func <= next_word.func;
        in_pixel <= next_word.pixel;
        in_frame_start <= next_word.frame_start;
        in_bin <= next_word.bin;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // error report, first ten in full
  task automatic report_error(input string what, input stretch_result_t want,
                              input stretch_result_t got);
    error_count++;
    if (error_count <= 10) begin
      $display("%0t %s: expected stretched=%0d range_zero=%0d bin=%0d cum=%0d,",
               $realtime, what, want.stretched, want.range_zero, want.bin_count,
               want.cumulative);
      $display("  got stretched=%0d range_zero=%0d bin=%0d cum=%0d",
               got.stretched, got.range_zero, got.bin_count, got.cumulative);
    end
  endtask

  // monitor: check accepted results in order, stall at random
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      got_result = {stretched_o, range_zero_o, bin_count_o, cumulative_count_o};
      if (results_due.size() == 0) begin
        report_error("result word with nothing expected", '0, got_result);
      end else begin
        want_result = results_due.pop_front();
        if (got_result.stretched !== want_result.stretched ||
            got_result.range_zero !== want_result.range_zero ||
            got_result.bin_count !== want_result.bin_count ||
            got_result.cumulative !== want_result.cumulative) begin
          report_error("result word mismatch", want_result, got_result);
        end
      end
    end
    out_stall <= rst_ni && !steady && ($urandom_range(0, 99) < 15);
  end

  // queue one request word
  task automatic add_word(input csh_pkg::func_e f, input logic [7:0] p, input logic fs,
                          input logic [7:0] b);
    words_to_send.push_back({f, p, fs, b});
  endtask

  // wait until every word is sent and every result has come back
  task automatic drain();
    while (words_to_send.size() != 0 || in_valid || results_due.size() != 0)
      @(negedge clk_i);
  endtask

  // span register write while the block is idle
  task automatic write_span(input logic [8:0] v);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    span_now = v;
  endtask

  // one frame: statistics pass, map pass, ascending readout; sometimes noise
  task automatic queue_frame();
    int lo;
    int hi;
    int n;
    int b;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(3, 8))
        add_word(csh_pkg::func_e'(2'($urandom_range(0, 3))), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      return;
    end
    lo = $urandom_range(0, 255);
    hi = ($urandom_range(0, 7) == 0) ? lo : $urandom_range(lo, 255);
    add_word(csh_pkg::FUNC_STAT, 8'(lo), 1'b1, 8'($urandom_range(0, 255)));
    add_word(csh_pkg::FUNC_STAT, 8'(hi), 1'b0, 8'($urandom_range(0, 255)));
    repeat ($urandom_range(0, 8))
      add_word(csh_pkg::FUNC_STAT, 8'($urandom_range(lo, hi)), 1'b0,
               8'($urandom_range(0, 255)));
    n = $urandom_range(4, 24);
    repeat (n) begin
      if ($urandom_range(0, 5) == 0)
        add_word(csh_pkg::FUNC_MAP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                 8'($urandom_range(0, 255)));
      else
        add_word(csh_pkg::FUNC_MAP, 8'($urandom_range(lo, hi)), 1'($urandom_range(0, 1)),
                 8'($urandom_range(0, 255)));
    end
    // readout restarts at bin 0 and climbs
    b = 0;
    n = 0;
    while (b <= 255 && n < 16) begin
      add_word(csh_pkg::FUNC_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
               8'(b));
      b += $urandom_range(1, 24);
      n++;
    end
    if ($urandom_range(0, 4) == 0)
      add_word(csh_pkg::FUNC_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
               8'($urandom_range(0, 255)));
  endtask

  // stimulus: directed words, then random phases at several spans
  initial begin
    logic [8:0] spans [8];
    int start;
    spans = '{9'd1, 9'd256, 9'd511, 9'd0, 9'd255, 9'd2, 9'd128, 9'd256};
    span_now = csh_pkg::SPAN_RESET;
    clear_stats();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // map before any statistics: flat range, counted in bin 0
    add_word(csh_pkg::FUNC_MAP, 8'd0, 1'b0, 8'd0);
    add_word(csh_pkg::FUNC_MAP, 8'd255, 1'b1, 8'd255);
    add_word(csh_pkg::FUNC_READ, 8'd0, 1'b0, 8'd0);
    add_word(csh_pkg::FUNC_READ, 8'd255, 1'b1, 8'd255);
    add_word(csh_pkg::FUNC_NONE, 8'd255, 1'b1, 8'd255);
    // flat frame
    add_word(csh_pkg::FUNC_STAT, 8'd100, 1'b1, 8'd0);
    add_word(csh_pkg::FUNC_MAP, 8'd100, 1'b0, 8'd0);
    // full range
    add_word(csh_pkg::FUNC_STAT, 8'd0, 1'b0, 8'd0);
    add_word(csh_pkg::FUNC_STAT, 8'd255, 1'b0, 8'd0);
    add_word(csh_pkg::FUNC_MAP, 8'd0, 1'b0, 8'd0);
    add_word(csh_pkg::FUNC_MAP, 8'd255, 1'b0, 8'd0);
    add_word(csh_pkg::FUNC_MAP, 8'd128, 1'b0, 8'd0);
    add_word(csh_pkg::FUNC_MAP, 8'd1, 1'b0, 8'd0);
    add_word(csh_pkg::FUNC_MAP, 8'd254, 1'b0, 8'd0);
    // narrow range, pixels below min and above max
    add_word(csh_pkg::FUNC_STAT, 8'd50, 1'b1, 8'd0);
    add_word(csh_pkg::FUNC_STAT, 8'd200, 1'b0, 8'd0);
    add_word(csh_pkg::FUNC_MAP, 8'd10, 1'b0, 8'd0);
    add_word(csh_pkg::FUNC_MAP, 8'd250, 1'b0, 8'd0);
    add_word(csh_pkg::FUNC_MAP, 8'd200, 1'b0, 8'd0);
    add_word(csh_pkg::FUNC_MAP, 8'd50, 1'b0, 8'd0);
    add_word(csh_pkg::FUNC_MAP, 8'd125, 1'b0, 8'd0);
    // readout, including out of order and a restart
    add_word(csh_pkg::FUNC_READ, 8'd0, 1'b0, 8'd0);
    add_word(csh_pkg::FUNC_READ, 8'd0, 1'b0, 8'd1);
    add_word(csh_pkg::FUNC_READ, 8'd0, 1'b0, 8'd255);
    add_word(csh_pkg::FUNC_READ, 8'd0, 1'b0, 8'd254);
    add_word(csh_pkg::FUNC_READ, 8'd0, 1'b0, 8'd0);
    drain();

    // random phases, one of them without any idling
    foreach (spans[k]) begin
      write_span(spans[k]);
      steady = (k == 3);
      start = 0;
      while (start < 112) begin
        wait (words_to_send.size() < 40);
        start += 1;
        queue_frame();
        start += 27;
        @(negedge clk_i);
      end
      drain();
    end
    steady = 1'b0;
    write_span(9'($urandom_range(1, 256)));
    repeat (6) queue_frame();
    drain();

    repeat (20) @(posedge clk_i);
    if (error_count == 0 && results_due.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/csh_pkg.sv
hw/rtl/csh_ctrl.sv
hw/rtl/csh_dpath.sv
hw/rtl/contrast_stretch_histogram.sv
tb/testbench.sv
